// File: hw/rtl/rtt_ws_pkg.sv
// shared constants and helpers for the rtt window statistics block
package rtt_ws_pkg;

   localparam int unsigned HIST_CELLS  = 60;
   localparam int unsigned CELL_W      = 6;
   localparam int unsigned LEVEL_W     = 3;
   localparam int unsigned BIN_W       = 4;
   localparam int unsigned DEC_DIV_W   = 24;
   localparam logic [31:0] EMPTY_MARK  = 32'hFFFF_FFFF;
   localparam logic [LEVEL_W-1:0] TOP_LEVEL = 3'd5;
   localparam logic [BIN_W-1:0]   TOP_BIN   = 4'd6;

   localparam logic OP_RECORD          = 1'b0;
   localparam logic OP_COMPUTE         = 1'b1;
   localparam logic REG_FILTER_ENABLE  = 1'b0;
   localparam logic REG_FILTER_PERCENT = 1'b1;

   typedef logic [31:0] word_type;

   // decade of a sample
   function automatic logic [LEVEL_W-1:0] hist_level(input word_type v);
      logic [LEVEL_W-1:0] lvl;
      if (v < 32'd1000)          lvl = 3'd0;
      else if (v < 32'd10000)    lvl = 3'd1;
      else if (v < 32'd100000)   lvl = 3'd2;
      else if (v < 32'd1000000)  lvl = 3'd3;
      else if (v < 32'd10000000) lvl = 3'd4;
      else                       lvl = TOP_LEVEL;
      return lvl;
   endfunction

   // bin width of a decade
   function automatic logic [DEC_DIV_W-1:0] dec_div(input logic [LEVEL_W-1:0] lvl);
      logic [DEC_DIV_W-1:0] d;
      case (lvl)
         3'd0:    d = 24'd100;
         3'd1:    d = 24'd1000;
         3'd2:    d = 24'd10000;
         3'd3:    d = 24'd100000;
         3'd4:    d = 24'd1000000;
         default: d = 24'd10000000;
      endcase
      return d;
   endfunction

endpackage

// File: hw/rtl/rtt_ws_ram.sv
// generic single-write, single-read ram with registered read data
module rtt_ws_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// File: hw/rtl/rtt_ws_div.sv
// restoring divider, one quotient bit per cycle
module rtt_ws_div #(
   parameter int unsigned DVD_W = 72,
   parameter int unsigned DVS_W = 24
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DVD_W-1:0] dividend,
   input  logic [DVS_W-1:0] divisor,
   output logic             done,
   output logic [DVD_W-1:0] quotient
);
   localparam int unsigned CNT_W = $clog2(DVD_W + 1);

   logic [DVD_W-1:0] quo_ff, quo_in;
   logic [DVS_W-1:0] rem_ff, rem_in, dvs_ff, dvs_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in, done_ff, done_in;
   logic [DVS_W:0]   trial;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quo_ff[DVD_W-1]};
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = DVS_W'(trial - {1'b0, dvs_ff});
            quo_in = {quo_ff[DVD_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DVS_W-1:0];
            quo_in = {quo_ff[DVD_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(DVD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule

// File: hw/rtl/rtt_ws_isqrt.sv
// 64-bit integer square root, two radicand bits per cycle
module rtt_ws_isqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] radicand,
   output logic        done,
   output logic [31:0] root
);
   logic [63:0] x_ff, x_in, res_ff, res_in, bit_ff, bit_in;
   logic        busy_ff, busy_in, done_ff, done_in;
   logic [63:0] trial;

   always_comb begin
      x_in    = x_ff;
      res_in  = res_ff;
      bit_in  = bit_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = res_ff + bit_ff;
      if (start) begin
         x_in    = radicand;
         res_in  = '0;
         bit_in  = 64'h4000_0000_0000_0000;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (x_ff >= trial) begin
            x_in   = x_ff - trial;
            res_in = (res_ff >> 1) + bit_ff;
         end else begin
            res_in = res_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         if (bit_ff[0]) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      x_ff   <= x_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
   end

   assign done = done_ff;
   assign root = res_ff[31:0];
endmodule

// File: hw/rtl/rtt_window_statistics.sv
// rtt window statistics: ring window, decade histogram, mean, deviation and filtered mean
//
//   channel | dir | handshake            | payload
//   req     | in  | req_tvalid/tready    | tuser op, tdata sample_us
//   rsp     | out | rsp_tvalid/tready    | tdata result fields, tuser stats_valid
//   csr     | in  | csr_we               | csr_index, csr_wdata
//
// a record item finds the bin by repeated subtraction of the decade step, one step per cycle,
// then reads the histogram cell and writes it back incremented
// a compute item takes up to three window walks, up to three divider passes and a square root
// req_tready is high only while the sequencer is idle; one finished result waits in the
// output register while the next item is taken, a second one stalls the sequencer
// reset is synchronous; it empties the window and the histogram through valid bits at once
module rtt_window_statistics
   import rtt_ws_pkg::*;
#(
   parameter int unsigned WINDOW_DEPTH     = 16,
   parameter int unsigned MIN_FILTER_COUNT = 4,
   parameter logic [31:0] MAX_RTT          = 32'd4294967294
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [31:0]  req_tdata,   // sample_us
   input  logic         req_tuser,   // op
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // stored_sample, hist_level, hist_bin, hist_count, window_average, std_deviation,
   // filtered_average, one pad bit
   output logic [167:0] rsp_tdata,
   output logic         rsp_tuser,   // stats_valid
   input  logic         csr_we,
   input  logic         csr_index,
   input  logic [9:0]   csr_wdata
);
   localparam int unsigned IDX_W = $clog2(WINDOW_DEPTH);
   localparam int unsigned CNT_W = $clog2(WINDOW_DEPTH + 1);
   localparam int unsigned SUM_W = 32 + CNT_W;
   localparam int unsigned DVD_W = 64 + CNT_W;
   localparam int unsigned DVS_W = CNT_W;
   localparam logic [IDX_W:0] WIN_END = (IDX_W + 1)'(WINDOW_DEPTH);
   localparam logic [IDX_W-1:0] WIN_LAST = IDX_W'(WINDOW_DEPTH - 1);

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_RDIV   = 4'd1;
   localparam logic [3:0] ST_RRD    = 4'd2;
   localparam logic [3:0] ST_RWR    = 4'd3;
   localparam logic [3:0] ST_P1     = 4'd4;
   localparam logic [3:0] ST_DAVG   = 4'd5;
   localparam logic [3:0] ST_P2     = 4'd6;
   localparam logic [3:0] ST_DVAR   = 4'd7;
   localparam logic [3:0] ST_SQRT   = 4'd8;
   localparam logic [3:0] ST_LIM    = 4'd9;
   localparam logic [3:0] ST_P3     = 4'd12;
   localparam logic [3:0] ST_DFAVG  = 4'd13;
   localparam logic [3:0] ST_FIN    = 4'd14;
   localparam logic [3:0] ST_EMPTY  = 4'd15;

   logic [3:0]            state_ff, state_in;
   logic [IDX_W:0]        walk_ff, walk_in;
   logic                  pend_ff, pend_in, pvld_ff, pvld_in;
   logic [63:0]           prod_ff, prod_in;
   logic [SUM_W-1:0]      sum_ff, sum_in;
   logic [DVD_W-1:0]      sq_ff, sq_in;
   logic [CNT_W-1:0]      n_ff, n_in, fn_ff, fn_in;
   logic [31:0]           avg_ff, avg_in, dev_ff, dev_in, favg_ff, favg_in;
   logic [IDX_W-1:0]      wpos_ff, wpos_in;
   logic [WINDOW_DEPTH-1:0] wvld_ff, wvld_in;
   logic [HIST_CELLS-1:0] hvld_ff, hvld_in;
   logic [31:0]           pmean_ff, pmean_in, pdev_ff, pdev_in;
   logic                  fen_ff;
   logic [9:0]            fpct_ff;
   logic [31:0]           sample_ff, sample_in;
   logic [LEVEL_W-1:0]    lvl_ff, lvl_in;
   logic [BIN_W-1:0]      bin_ff, bin_in;
   logic [CELL_W-1:0]     cell_ff, cell_in;

   logic                  rvalid_ff, rvalid_in, rstats_ff, rstats_in;
   logic [31:0]           rstored_ff, rstored_in, rcount_ff, rcount_in;
   logic [LEVEL_W-1:0]    rlvl_ff, rlvl_in;
   logic [BIN_W-1:0]      rbin_ff, rbin_in;
   logic [31:0]           ravg_ff, ravg_in, rdev_ff, rdev_in, rfavg_ff, rfavg_in;

   logic                  accept, out_free, walking, issue, walk_done;
   logic [31:0]           clamped, win_rd, hist_rd, diff, pdiff, mul_a, mul_b;
   logic [38:0]           pdiff_x100;
   logic                  win_we, hist_we;
   logic [31:0]           hist_wd;
   logic                  div_go, div_done, sqrt_go, sqrt_done;
   logic [DVD_W-1:0]      div_a, div_q;
   logic [DVS_W-1:0]      div_b;
   logic [31:0]           sqrt_root;
   logic [LEVEL_W-1:0]    acc_lvl;
   logic                  bypass;

   function automatic logic [31:0] clamp_rtt(input logic [31:0] v);
      return (v > MAX_RTT) ? MAX_RTT : v;
   endfunction

   assign accept    = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign out_free  = !rvalid_ff || rsp_tready;
   assign clamped   = clamp_rtt(req_tdata);
   assign acc_lvl   = hist_level(clamped);
   assign walking   = (state_ff == ST_P1) || (state_ff == ST_P2) || (state_ff == ST_P3);
   assign issue     = walking && (walk_ff != WIN_END);
   assign walk_done = (walk_ff == WIN_END) && !pend_ff && !pvld_ff;
   assign diff      = (win_rd > avg_ff) ? (win_rd - avg_ff) : (avg_ff - win_rd);
   assign pdiff     = (win_rd > pmean_ff) ? (win_rd - pmean_ff) : (pmean_ff - win_rd);
   // 100 times the distance from the previous mean
   assign pdiff_x100 = 39'({pdiff, 6'd0}) + 39'({pdiff, 5'd0}) + 39'({pdiff, 2'd0});
   assign mul_a     = (state_ff == ST_LIM) ? {22'd0, fpct_ff} : diff;
   assign mul_b     = (state_ff == ST_LIM) ? pdev_ff : diff;
   assign bypass    = (pmean_ff == EMPTY_MARK) || (pdev_ff == EMPTY_MARK)
                      || (32'(n_ff) < 32'(MIN_FILTER_COUNT));

   rtt_ws_ram #(.WIDTH(32), .DEPTH(WINDOW_DEPTH)) u_win_ram (
      .clock   (clock),
      .wr_en   (win_we),
      .wr_addr (wpos_ff),
      .wr_data (clamped),
      .rd_addr (walk_ff[IDX_W-1:0]),
      .rd_data (win_rd)
   );

   rtt_ws_ram #(.WIDTH(32), .DEPTH(HIST_CELLS)) u_hist_ram (
      .clock   (clock),
      .wr_en   (hist_we),
      .wr_addr (cell_ff),
      .wr_data (hist_wd),
      .rd_addr (cell_ff),
      .rd_data (hist_rd)
   );

   rtt_ws_div #(.DVD_W(DVD_W), .DVS_W(DVS_W)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_go),
      .dividend (div_a),
      .divisor  (div_b),
      .done     (div_done),
      .quotient (div_q)
   );

   rtt_ws_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_go),
      .radicand (div_q[63:0]),
      .done     (sqrt_done),
      .root     (sqrt_root)
   );

   always_comb begin
      state_in  = state_ff;
      walk_in   = walk_ff;
      pend_in   = issue && wvld_ff[walk_ff[IDX_W-1:0]];
      pvld_in   = 1'b0;
      prod_in   = prod_ff;
      sum_in    = sum_ff;
      sq_in     = sq_ff;
      n_in      = n_ff;
      fn_in     = fn_ff;
      avg_in    = avg_ff;
      dev_in    = dev_ff;
      favg_in   = favg_ff;
      wpos_in   = wpos_ff;
      wvld_in   = wvld_ff;
      hvld_in   = hvld_ff;
      pmean_in  = pmean_ff;
      pdev_in   = pdev_ff;
      sample_in = sample_ff;
      lvl_in    = lvl_ff;
      bin_in    = bin_ff;
      cell_in   = cell_ff;
      rvalid_in = rvalid_ff && !rsp_tready;
      rstats_in = rstats_ff;
      rstored_in = rstored_ff;
      rcount_in = rcount_ff;
      rlvl_in   = rlvl_ff;
      rbin_in   = rbin_ff;
      ravg_in   = ravg_ff;
      rdev_in   = rdev_ff;
      rfavg_in  = rfavg_ff;
      win_we    = 1'b0;
      hist_we   = 1'b0;
      hist_wd   = (hvld_ff[cell_ff] ? hist_rd : 32'd0) + 32'd1;
      div_go    = 1'b0;
      div_a     = '0;
      div_b     = '0;
      sqrt_go   = 1'b0;

      if (issue) begin
         walk_in = walk_ff + 1'b1;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_tuser == OP_RECORD) begin
                  win_we    = 1'b1;
                  wvld_in[wpos_ff] = 1'b1;
                  wpos_in   = (wpos_ff == WIN_LAST) ? '0 : wpos_ff + 1'b1;
                  sample_in = clamped;
                  lvl_in    = acc_lvl;
                  sum_in    = SUM_W'(clamped);
                  bin_in    = '0;
                  state_in  = ST_RDIV;
               end else begin
                  walk_in  = '0;
                  sum_in   = '0;
                  n_in     = '0;
                  state_in = ST_P1;
               end
            end
         end
         ST_RDIV: begin
            // one decade step taken off per cycle, the top decade stops at its last bin
            if (sum_ff < SUM_W'(dec_div(lvl_ff)) || (lvl_ff == TOP_LEVEL && bin_ff == TOP_BIN))
            begin
               cell_in  = CELL_W'({lvl_ff, 3'b000}) + CELL_W'({lvl_ff, 1'b0})
                          + CELL_W'(bin_ff);
               state_in = ST_RRD;
            end else begin
               sum_in = sum_ff - SUM_W'(dec_div(lvl_ff));
               bin_in = bin_ff + 1'b1;
            end
         end
         ST_RRD: begin
            state_in = ST_RWR;
         end
         ST_RWR: begin
            if (out_free) begin
               hist_we    = 1'b1;
               hvld_in[cell_ff] = 1'b1;
               rvalid_in  = 1'b1;
               rstats_in  = 1'b0;
               rstored_in = sample_ff;
               rlvl_in    = lvl_ff;
               rbin_in    = bin_ff;
               rcount_in  = hist_wd;
               ravg_in    = '0;
               rdev_in    = '0;
               rfavg_in   = '0;
               state_in   = ST_IDLE;
            end
         end
         ST_P1: begin
            if (pend_ff) begin
               sum_in = sum_ff + SUM_W'(win_rd);
               n_in   = n_ff + 1'b1;
            end
            if (walk_done) begin
               if (n_ff == '0) begin
                  state_in = ST_EMPTY;
               end else begin
                  div_go   = 1'b1;
                  div_a    = DVD_W'(sum_ff);
                  div_b    = DVS_W'(n_ff);
                  state_in = ST_DAVG;
               end
            end
         end
         ST_DAVG: begin
            if (div_done) begin
               avg_in = div_q[31:0];
               if (n_ff > CNT_W'(1)) begin
                  walk_in  = '0;
                  sq_in    = '0;
                  state_in = ST_P2;
               end else begin
                  dev_in   = '0;
                  state_in = ST_LIM;
               end
            end
         end
         ST_P2: begin
            // product of the previous entry is added while the next one is squared
            prod_in = mul_a * mul_b;
            pvld_in = pend_ff;
            if (pvld_ff) begin
               sq_in = sq_ff + DVD_W'(prod_ff);
            end
            if (walk_done) begin
               div_go   = 1'b1;
               div_a    = sq_ff;
               div_b    = DVS_W'(n_ff - 1'b1);
               state_in = ST_DVAR;
            end
         end
         ST_DVAR: begin
            if (div_done) begin
               sqrt_go  = 1'b1;
               state_in = ST_SQRT;
            end
         end
         ST_SQRT: begin
            if (sqrt_done) begin
               dev_in   = sqrt_root;
               state_in = ST_LIM;
            end
         end
         ST_LIM: begin
            if (!fen_ff || bypass) begin
               fn_in    = n_ff;
               state_in = ST_DFAVG;
               div_go   = 1'b1;
               div_a    = DVD_W'(sum_ff);
               div_b    = DVS_W'(n_ff);
            end else begin
               // percent times previous deviation, held for the band test
               prod_in  = mul_a * mul_b;
               walk_in  = '0;
               sum_in   = '0;
               fn_in    = '0;
               state_in = ST_P3;
            end
         end
         ST_P3: begin
            // in the band while 100 times the distance stays within percent times deviation
            if (pend_ff && 64'(pdiff_x100) <= prod_ff) begin
               sum_in = sum_ff + SUM_W'(win_rd);
               fn_in  = fn_ff + 1'b1;
            end
            if (walk_done) begin
               if (fn_ff == '0) begin
                  favg_in  = '0;
                  state_in = ST_FIN;
               end else begin
                  div_go   = 1'b1;
                  div_a    = DVD_W'(sum_ff);
                  div_b    = DVS_W'(fn_ff);
                  state_in = ST_DFAVG;
               end
            end
         end
         ST_DFAVG: begin
            if (div_done) begin
               favg_in  = div_q[31:0];
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (out_free) begin
               pmean_in   = clamp_rtt(avg_ff);
               pdev_in    = clamp_rtt(dev_ff);
               rvalid_in  = 1'b1;
               rstats_in  = 1'b1;
               rstored_in = '0;
               rlvl_in    = '0;
               rbin_in    = '0;
               rcount_in  = '0;
               ravg_in    = clamp_rtt(avg_ff);
               rdev_in    = clamp_rtt(dev_ff);
               rfavg_in   = clamp_rtt(favg_ff);
               state_in   = ST_IDLE;
            end
         end
         ST_EMPTY: begin
            if (out_free) begin
               if (!fen_ff) begin
                  pmean_in = EMPTY_MARK;
                  pdev_in  = EMPTY_MARK;
               end
               rvalid_in  = 1'b1;
               rstats_in  = 1'b0;
               rstored_in = '0;
               rlvl_in    = '0;
               rbin_in    = '0;
               rcount_in  = '0;
               ravg_in    = EMPTY_MARK;
               rdev_in    = '0;
               rfavg_in   = '0;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         walk_ff   <= '0;
         pend_ff   <= 1'b0;
         pvld_ff   <= 1'b0;
         wpos_ff   <= '0;
         wvld_ff   <= '0;
         hvld_ff   <= '0;
         pmean_ff  <= EMPTY_MARK;
         pdev_ff   <= EMPTY_MARK;
         fen_ff    <= 1'b0;
         fpct_ff   <= 10'd200;
         rvalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         walk_ff   <= walk_in;
         pend_ff   <= pend_in;
         pvld_ff   <= pvld_in;
         wpos_ff   <= wpos_in;
         wvld_ff   <= wvld_in;
         hvld_ff   <= hvld_in;
         pmean_ff  <= pmean_in;
         pdev_ff   <= pdev_in;
         rvalid_ff <= rvalid_in;
         if (csr_we && csr_index == REG_FILTER_ENABLE) begin
            fen_ff <= csr_wdata[0];
         end
         if (csr_we && csr_index == REG_FILTER_PERCENT) begin
            fpct_ff <= csr_wdata;
         end
      end
      prod_ff    <= prod_in;
      sum_ff     <= sum_in;
      sq_ff      <= sq_in;
      n_ff       <= n_in;
      fn_ff      <= fn_in;
      avg_ff     <= avg_in;
      dev_ff     <= dev_in;
      favg_ff    <= favg_in;
      sample_ff  <= sample_in;
      lvl_ff     <= lvl_in;
      bin_ff     <= bin_in;
      cell_ff    <= cell_in;
      rstats_ff  <= rstats_in;
      rstored_ff <= rstored_in;
      rcount_ff  <= rcount_in;
      rlvl_ff    <= rlvl_in;
      rbin_ff    <= rbin_in;
      ravg_ff    <= ravg_in;
      rdev_ff    <= rdev_in;
      rfavg_ff   <= rfavg_in;
   end

   assign rsp_tvalid = rvalid_ff;
   assign rsp_tuser  = rstats_ff;
   assign rsp_tdata  = {1'b0, rfavg_ff, rdev_ff, ravg_ff, rcount_ff, rbin_ff, rlvl_ff,
                        rstored_ff};

   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_tready)
      else $error("sequencer took a transfer while busy");

   a_stats_no_record: assert property (@(posedge clock) disable iff (reset)
      (rvalid_ff && rstats_ff) |-> (rstored_ff == '0 && rcount_ff == '0))
      else $error("statistics result carries record fields");

   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      walk_ff <= WIN_END)
      else $error("window walk ran past the depth");

   a_div_state: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DAVG || state_ff == ST_DVAR || state_ff == ST_DFAVG))
      else $error("divider finished outside a divide wait");
endmodule
